// ----- sv/tqd_pkg.sv -----
// tqd_pkg: shared types, codes and constants of the tone queue sequencer
// used by tqd_ctrl, tqd_datapath and tone_queue_decay_sequencer
// no dependencies
package tqd_pkg;

    localparam int TQD_QUEUE_DEPTH = 128;

    localparam int FREQ_W   = 16;
    localparam int LEN_W    = 16;
    localparam int DUTY_W   = 10;
    localparam int PERIOD_W = 8;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DUTY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 1'b1;

    localparam logic [DUTY_W-1:0]   INITIAL_DUTY_RST = 10'd511;
    localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST  = 8'd20;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } tqd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } tqd_status_t;

    // stepped decay of the duty level, clamped at zero
    function automatic logic [DUTY_W-1:0] decay(input logic [DUTY_W-1:0] d);
        logic [DUTY_W-1:0] r;
        if (d > 10'd200)
            r = d - 10'd20;
        else if (d > 10'd100)
            r = d - 10'd15;
        else if (d > 10'd50)
            r = d - 10'd10;
        else if (d > 10'd10)
            r = d - 10'd7;
        else if (d > 10'd4)
            r = d - 10'd4;
        else
            r = '0;
        return r;
    endfunction

endpackage

// ----- sv/tqd_ctrl.sv -----
// tqd_ctrl: two-state controller, takes one item and runs it through the datapath
// depends on tqd_pkg
module tqd_ctrl
    import tqd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  tqd_status_t status,
    output tqd_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // wait here until the result register can take the item
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- sv/tqd_datapath.sv -----
// tqd_datapath: note queue memory, playback counters, duty decay and result register
// depends on tqd_pkg
module tqd_datapath
    import tqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = TQD_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tqd_cmd_t              cmd,
    output tqd_status_t           status,
    input  logic [OP_W-1:0]       operation,
    input  logic [FREQ_W-1:0]     note_freq,
    input  logic [LEN_W-1:0]      duration_ms,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FREQ_W-1:0]     tone_freq,
    output logic [DUTY_W-1:0]     duty,
    output logic                  busy_res,
    output logic                  overflow
);

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W  = FREQ_W + LEN_W;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        logic [IDX_W:0] inc;
        inc = {1'b0, i} + (IDX_W+1)'(1);
        return (inc >= (IDX_W+1)'(QUEUE_DEPTH)) ? '0 : inc[IDX_W-1:0];
    endfunction

    // queue memory and its registered read port
    logic [ENT_W-1:0] q_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] q_rd_reg;

    // captured item
    logic [OP_W-1:0]   op_reg;
    logic [FREQ_W-1:0] nf_reg;
    logic [LEN_W-1:0]  nl_reg;

    // configuration
    logic [DUTY_W-1:0]   init_duty_reg;
    logic [PERIOD_W-1:0] period_reg;

    // playback state
    logic [IDX_W-1:0]    head_reg,    head_next;
    logic [IDX_W-1:0]    tail_reg,    tail_next;
    logic [FILL_W-1:0]   fill_reg,    fill_next;
    logic                playing_reg, playing_next;
    logic [FREQ_W-1:0]   cur_freq_reg, cur_freq_next;
    logic [LEN_W-1:0]    cur_len_reg,  cur_len_next;
    logic [LEN_W-1:0]    elapsed_reg,  elapsed_next;
    logic [PERIOD_W-1:0] phase_reg,    phase_next;
    logic [DUTY_W-1:0]   level_reg,    level_next;
    logic [DUTY_W-1:0]   driven_reg,   driven_next;
    logic                stop_reg,     stop_next;

    // result register
    logic              out_valid_reg;
    logic [FREQ_W-1:0] tone_freq_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic              busy_reg;
    logic              overflow_reg;

    logic        mem_we;
    logic        dropped;
    logic        tone_on;
    logic [PERIOD_W:0] phase_inc;

    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        playing_next  = playing_reg;
        cur_freq_next = cur_freq_reg;
        cur_len_next  = cur_len_reg;
        elapsed_next  = elapsed_reg;
        phase_next    = phase_reg;
        level_next    = level_reg;
        driven_next   = driven_reg;
        stop_next     = stop_reg;
        mem_we        = 1'b0;
        dropped       = 1'b0;
        phase_inc     = '0;
        case (op_reg)
            OP_APPEND:
            begin
                if (fill_reg >= FILL_W'(QUEUE_DEPTH))
                    dropped = 1'b1;
                else
                begin
                    mem_we    = 1'b1;
                    tail_next = next_slot(tail_reg);
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            OP_TICK:
            begin
                if (!playing_reg && fill_reg != '0)
                begin
                    head_next = next_slot(head_reg);
                    fill_next = fill_reg - FILL_W'(1);
                    if (stop_reg)
                    begin
                        // flush: this note and the rest of the queue are dropped
                        stop_next = 1'b0;
                        head_next = tail_reg;
                        fill_next = '0;
                    end
                    else
                    begin
                        cur_freq_next = q_rd_reg[ENT_W-1:LEN_W];
                        cur_len_next  = q_rd_reg[LEN_W-1:0];
                        elapsed_next  = '0;
                        phase_next    = '0;
                        level_next    = init_duty_reg;
                        driven_next   = '0;
                        playing_next  = (q_rd_reg[LEN_W-1:0] != '0);
                    end
                end
                if (playing_next)
                begin
                    if (cur_freq_next != '0 && phase_next == '0)
                    begin
                        driven_next = level_next;
                        level_next  = decay(level_next);
                    end
                    if (elapsed_next != '1)
                        elapsed_next = elapsed_next + LEN_W'(1);
                    if (cur_freq_next == '0)
                    begin
                        if (elapsed_next >= cur_len_next)
                            playing_next = 1'b0;
                    end
                    else
                    begin
                        phase_inc  = {1'b0, phase_next} + (PERIOD_W+1)'(1);
                        phase_next = (phase_inc >= {1'b0, period_reg}) ?
                                     '0 : phase_inc[PERIOD_W-1:0];
                        if (phase_next == '0 && elapsed_next >= cur_len_next)
                            playing_next = 1'b0;
                    end
                end
            end
            OP_STOP:
            begin
                stop_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign tone_on = playing_next && cur_freq_next != '0;

    // queue memory, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
            q_mem[tail_reg] <= {nf_reg, nl_reg};
        q_rd_reg <= q_mem[head_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= operation;
            nf_reg <= note_freq;
            nl_reg <= duration_ms;
        end
        if (cmd.exec)
        begin
            tone_freq_reg <= tone_on ? cur_freq_next : '0;
            duty_reg      <= tone_on ? driven_next : '0;
            busy_reg      <= playing_next || fill_next != '0;
            overflow_reg  <= dropped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_duty_reg <= INITIAL_DUTY_RST;
            period_reg    <= STEP_PERIOD_RST;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            playing_reg   <= 1'b0;
            cur_freq_reg  <= '0;
            cur_len_reg   <= '0;
            elapsed_reg   <= '0;
            phase_reg     <= '0;
            level_reg     <= '0;
            driven_reg    <= '0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INITIAL_DUTY: init_duty_reg <= cfg_data;
                    CFG_STEP_PERIOD:  period_reg    <= cfg_data[PERIOD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.exec)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                fill_reg      <= fill_next;
                playing_reg   <= playing_next;
                cur_freq_reg  <= cur_freq_next;
                cur_len_reg   <= cur_len_next;
                elapsed_reg   <= elapsed_next;
                phase_reg     <= phase_next;
                level_reg     <= level_next;
                driven_reg    <= driven_next;
                stop_reg      <= stop_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign tone_freq = tone_freq_reg;
    assign duty      = duty_reg;
    assign busy_res  = busy_reg;
    assign overflow  = overflow_reg;

endmodule

// ----- sv/tone_queue_decay_sequencer.sv -----
// tone_queue_decay_sequencer: top level of the note queue player with duty decay
// depends on tqd_pkg, tqd_ctrl, tqd_datapath
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    operation, note_freq, duration_ms
//  out      output     out_valid / out_stall  tone_freq, duty, busy_res, overflow
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// each item goes through two steps: capture, while the queue head is read from
// the memory's registered port, and update of the counters and the result
// register. no clearing pass: the block takes items straight after reset. a
// stalled result holds the update step of the next item until it is taken.
module tone_queue_decay_sequencer
    import tqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = TQD_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [FREQ_W-1:0]     note_freq,
    input  logic [LEN_W-1:0]      duration_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FREQ_W-1:0]     tone_freq,
    output logic [DUTY_W-1:0]     duty,
    output logic                  busy_res,
    output logic                  overflow,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tqd_cmd_t    cmd;
    tqd_status_t status;

    tqd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tqd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .operation   (operation),
        .note_freq   (note_freq),
        .duration_ms (duration_ms),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tone_freq   (tone_freq),
        .duty        (duty),
        .busy_res    (busy_res),
        .overflow    (overflow)
    );

`ifndef SYNTHESIS
    // an accepted item blocks the input for at least the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in work");

    // a dropped append only happens with a full, hence busy, queue
    a_overflow_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> busy_res)
        else $error("overflow reported with an empty queue");

    // no duty is shown while the tone is off
    a_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tone_freq == '0) |-> (duty == '0))
        else $error("duty driven with the tone off");
`endif

endmodule

// ----- tb/tb_tone_queue_decay_sequencer.sv -----
// tb_tone_queue_decay_sequencer: self-checking bench for the note queue player with duty decay
// predicts every result from its own copy of queue, note timing and decay state
// depends on tqd_pkg and tone_queue_decay_sequencer
module tb_tone_queue_decay_sequencer;
    import tqd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [FREQ_W-1:0] freq;
        logic [LEN_W-1:0]  len;
        logic              hold_for_drain;
    } note_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic              busy;
        logic              dropped;
    } player_status_t;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0]       operation = OP_APPEND;
    logic [FREQ_W-1:0]     note_freq = '0;
    logic [LEN_W-1:0]      duration_ms = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [FREQ_W-1:0]     tone_freq;
    logic [DUTY_W-1:0]     duty;
    logic busy_res;
    logic overflow;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_INITIAL_DUTY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tone_queue_decay_sequencer DUT (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // player state mirrored for prediction
    logic [FREQ_W-1:0]   pq_freq [TQD_QUEUE_DEPTH];
    logic [LEN_W-1:0]    pq_len  [TQD_QUEUE_DEPTH];
    int                  pq_head = 0;
    int                  pq_tail = 0;
    int                  pq_fill = 0;
    bit                  note_active = 0;
    logic [FREQ_W-1:0]   note_freq_now = '0;
    logic [LEN_W-1:0]    note_len_now = '0;
    logic [LEN_W-1:0]    note_elapsed = '0;
    logic [PERIOD_W-1:0] decay_phase = '0;
    logic [DUTY_W-1:0]   decay_level = '0;
    logic [DUTY_W-1:0]   duty_shown = '0;
    bit                  flush_armed = 0;
    logic [DUTY_W-1:0]   set_duty = INITIAL_DUTY_RST;
    logic [PERIOD_W-1:0] set_period = STEP_PERIOD_RST;

    note_item_t     item_backlog [$];
    player_status_t awaited_status [$];
    note_item_t     item_on_bus;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int results_seen = 0;
    int tone_results = 0;
    int drops_seen = 0;
    int faults = 0;

    function automatic logic [DUTY_W-1:0] decayed_level(input logic [DUTY_W-1:0] lvl);
        logic [4:0] drop;
        drop = (lvl > 200) ? 5'd20 : (lvl > 100) ? 5'd15 : (lvl > 50) ? 5'd10 :
               (lvl > 10) ? 5'd7 : 5'd4;
        return (lvl > drop) ? lvl - drop : '0;
    endfunction

    function automatic void run_one_ms();
        logic [FREQ_W-1:0] f;
        logic [LEN_W-1:0]  l;
        if (!note_active && pq_fill > 0)
        begin
            f = pq_freq[pq_head];
            l = pq_len[pq_head];
            pq_head = (pq_head + 1) % TQD_QUEUE_DEPTH;
            pq_fill--;
            if (flush_armed)
            begin
                // this note and all behind it are thrown away
                flush_armed = 0;
                pq_head = pq_tail;
                pq_fill = 0;
            end
            else
            begin
                note_freq_now = f;
                note_len_now = l;
                note_elapsed = '0;
                decay_phase = '0;
                decay_level = set_duty;
                duty_shown = '0;
                note_active = (l != 0);
            end
        end
        if (note_active)
        begin
            if (note_freq_now != 0 && decay_phase == 0)
            begin
                duty_shown = decay_level;
                decay_level = decayed_level(decay_level);
            end
            if (note_elapsed != 16'hFFFF)
                note_elapsed++;
            if (note_freq_now == 0)
            begin
                if (note_elapsed >= note_len_now)
                    note_active = 0;
            end
            else
            begin
                // a period of zero acts as one
                if (int'(decay_phase) + 1 >= int'(set_period))
                    decay_phase = '0;
                else
                    decay_phase = decay_phase + 1'b1;
                if (decay_phase == 0 && note_elapsed >= note_len_now)
                    note_active = 0;
            end
        end
    endfunction

    function automatic player_status_t advance_player(input note_item_t it);
        player_status_t st;
        bit tone_on;
        st.dropped = 1'b0;
        case (it.op)
            OP_APPEND:
            begin
                if (pq_fill >= TQD_QUEUE_DEPTH)
                    st.dropped = 1'b1;
                else
                begin
                    pq_freq[pq_tail] = it.freq;
                    pq_len[pq_tail] = it.len;
                    pq_tail = (pq_tail + 1) % TQD_QUEUE_DEPTH;
                    pq_fill++;
                end
            end
            OP_TICK: run_one_ms();
            OP_STOP: flush_armed = 1;
            default: ;
        endcase
        tone_on = note_active && note_freq_now != 0;
        st.freq = tone_on ? note_freq_now : '0;
        st.duty = tone_on ? duty_shown : '0;
        st.busy = note_active || pq_fill > 0;
        return st;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                awaited_status.push_back(advance_player(item_on_bus));
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (item_backlog.size() > 0 &&
                    !(item_backlog[0].hold_for_drain && awaited_status.size() > 0) &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    item_on_bus = item_backlog.pop_front();
                    in_valid <= 1'b1;
                    operation <= item_on_bus.op;
                    note_freq <= item_on_bus.freq;
                    duration_ms <= item_on_bus.len;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void note_fault(input string what, input int got, input int want);
        faults++;
        if (faults <= 10)
            $display("%0t: mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
    endfunction

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor_blk
        player_status_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (awaited_status.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: result with nothing awaited: freq %0d duty %0d",
                                 $realtime, tone_freq, duty);
                end
                else
                begin
                    want = awaited_status.pop_front();
                    if (want.freq != 0)
                        tone_results++;
                    if (want.dropped)
                        drops_seen++;
                    if (tone_freq !== want.freq)
                        note_fault("tone_freq", tone_freq, want.freq);
                    if (duty !== want.duty)
                        note_fault("duty", duty, want.duty);
                    if (busy_res !== want.busy)
                        note_fault("busy_res", busy_res, want.busy);
                    if (overflow !== want.dropped)
                        note_fault("overflow", overflow, want.dropped);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void queue_item(input logic [OP_W-1:0] op, input int f, input int l,
                                       input bit hold = 0);
        note_item_t it;
        it.op = op;
        it.freq = f[FREQ_W-1:0];
        it.len = l[LEN_W-1:0];
        it.hold_for_drain = hold;
        item_backlog.push_back(it);
    endfunction

    function automatic int pick_freq();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return 0;
        if (r < 25)
            return 65535;
        if (r < 30)
            return 1;
        return $urandom_range(65535);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 80)
            return $urandom_range(40, 1);
        return $urandom_range(300, 41);
    endfunction

    function automatic void queue_ticks(input int n);
        repeat (n)
            queue_item(OP_TICK, $urandom_range(65535), $urandom_range(65535));
    endfunction

    // fill the queue past its depth, then flush it
    function automatic void queue_fill_burst();
        repeat ($urandom_range(TQD_QUEUE_DEPTH + 6, TQD_QUEUE_DEPTH + 1))
            queue_item(OP_APPEND, pick_freq(), pick_len());
        queue_item(OP_STOP, $urandom_range(65535), $urandom_range(65535));
        queue_ticks(3);
    endfunction

    function automatic void queue_random(input int target);
        int made;
        int k;
        int r;
        made = 0;
        while (made < target)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                k = $urandom_range(3, 1);
                repeat (k)
                    queue_item(OP_APPEND, pick_freq(), pick_len());
                made += k;
                k = $urandom_range(40, 1);
                queue_ticks(k);
                made += k;
            end
            else if (r < 65)
            begin
                k = $urandom_range(30, 1);
                queue_ticks(k);
                made += k;
            end
            else if (r < 75)
            begin
                queue_item(OP_STOP, $urandom_range(65535), $urandom_range(65535));
                k = $urandom_range(10);
                queue_ticks(k);
                made += k + 1;
            end
            else if (r < 80)
                queue_item(OP_UNUSED, $urandom_range(65535), $urandom_range(65535));
            else if (r < 83)
            begin
                queue_fill_burst();
                made += TQD_QUEUE_DEPTH;
            end
            else
            begin
                queue_item(OP_APPEND, $urandom_range(65535), $urandom_range(300));
                made++;
            end
        end
    endfunction

    function automatic void queue_directed();
        queue_item(OP_TICK, 0, 0);
        queue_item(OP_UNUSED, 65535, 65535);
        queue_item(OP_STOP, 0, 0);
        queue_item(OP_APPEND, 1000, 5);
        queue_item(OP_TICK, 0, 0);           // flush tick, plays nothing
        queue_item(OP_APPEND, 0, 3);         // silence
        queue_item(OP_APPEND, 65535, 0);     // zero duration
        queue_item(OP_APPEND, 440, 25);
        queue_item(OP_APPEND, 1, 1);
        queue_ticks(10);
        queue_item(OP_STOP, 0, 0);           // stop while a tone plays
        queue_item(OP_APPEND, 65535, 2);
        queue_ticks(1);
    endfunction

    // leaves a long tone mid-period so the next period setting cuts its phase short
    function automatic void queue_tone_left_playing();
        queue_item(OP_STOP, 0, 0);
        queue_item(OP_APPEND, 1, 1);
        queue_ticks(600);
        queue_item(OP_APPEND, 1000, 1000);
        queue_ticks(60);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_INITIAL_DUTY)
            set_duty = val[DUTY_W-1:0];
        else
            set_period = val[PERIOD_W-1:0];
    endtask

    task automatic wait_drained();
        while (item_backlog.size() > 0 || in_valid || awaited_status.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, no idling
        queue_directed();
        queue_random(260);
        wait_drained();

        write_reg(CFG_INITIAL_DUTY, 10'd1023);
        write_reg(CFG_STEP_PERIOD, 10'd1);
        send_idle_pct = 55;
        stall_pct = 0;
        queue_random(140);
        queue_item(OP_TICK, 0, 0, 1);        // sender holds until all results are in
        queue_random(140);
        queue_fill_burst();
        wait_drained();

        write_reg(CFG_INITIAL_DUTY, 10'd0);
        write_reg(CFG_STEP_PERIOD, 10'd255);
        send_idle_pct = 0;
        stall_pct = 55;
        queue_random(200);
        queue_tone_left_playing();
        wait_drained();

        write_reg(CFG_INITIAL_DUTY, 10'($urandom_range(1022, 1)));
        write_reg(CFG_STEP_PERIOD, 10'd0);
        send_idle_pct = 31;
        stall_pct = 31;
        queue_random(220);
        queue_fill_burst();
        wait_drained();

        $display("%0d items sent, %0d results checked over four register settings",
                 items_sent, results_seen);
        $display("%0d results with a tone sounding, %0d appends dropped on a full queue, %0d faults",
                 tone_results, drops_seen, faults);
        if (faults == 0 && awaited_status.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d items sent, %0d results seen", items_sent, results_seen);
        $display("Test completed with failures");
        $finish;
    end

endmodule
